// ===== hw/rtl/bezier_point_and_tangent_unit_defines.svh =====
// Assertion macros shared by the Bezier point and tangent unit.
`ifndef BEZIER_POINT_AND_TANGENT_UNIT_DEFINES_SVH
`define BEZIER_POINT_AND_TANGENT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BPT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bpt assertion failed");
`define BPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpt assertion failed");
`else
`define BPT_ASSERT(label, clk, rst, prop)
`define BPT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/bpt_pkg.sv =====
// Types, constants and interpolation helpers of the Bezier point and tangent unit.
package bpt_pkg;

  localparam int MAX_POINTS = 6;
  localparam int NUM_LEVELS = MAX_POINTS - 2;
  localparam int NUM_REGS   = MAX_POINTS + 1;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);
  localparam int NPTS_W     = 3;
  localparam int T_W        = 17;
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = DIFF_W + T_W + 1;
  localparam int TAN_W      = 36;
  localparam int CFG_W      = 2 * COORD_W;
  localparam int LATENCY    = 2 * NUM_LEVELS + 3;

  localparam logic [T_W-1:0]       T_ONE          = T_W'(65536);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CP_FIRST   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CP_LAST    = CFG_IDX_W'(MAX_POINTS);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [TAN_W-1:0]   tan_t;

  // one interpolation level: points plus the pair picked for the final step
  typedef struct packed {
    logic                         valid;
    logic [NPTS_W-1:0]            npts;
    logic [T_W-1:0]               t;
    coord_t [MAX_POINTS-1:0]      px;
    coord_t [MAX_POINTS-1:0]      py;
    coord_t                       bx0;
    coord_t                       bx1;
    coord_t                       by0;
    coord_t                       by1;
  } lvl_t;

  // product half of a level
  typedef struct packed {
    logic                         valid;
    logic [NPTS_W-1:0]            npts;
    logic [T_W-1:0]               t;
    coord_t [MAX_POINTS-1:0]      ax;
    coord_t [MAX_POINTS-1:0]      ay;
    prod_t  [MAX_POINTS-1:0]      dx;
    prod_t  [MAX_POINTS-1:0]      dy;
    coord_t                       bx0;
    coord_t                       bx1;
    coord_t                       by0;
    coord_t                       by1;
  } mul_t;

  typedef struct packed {
    logic   valid;
    logic   single;
    coord_t bx0;
    coord_t by0;
    prod_t  dx;
    prod_t  dy;
    tan_t   tx;
    tan_t   ty;
  } fin_t;

  // (b - a) * t, full precision
  function automatic prod_t lerp_mul(coord_t a, coord_t b, logic [T_W-1:0] t);
    logic signed [DIFF_W-1:0] d;
    logic signed [T_W:0]      ts;
    d  = DIFF_W'(b) - DIFF_W'(a);
    ts = $signed({1'b0, t});
    return PROD_W'(d * ts);
  endfunction

  // a + floor(p / 2^16); stays between a and b
  function automatic coord_t lerp_add(coord_t a, prod_t p);
    logic signed [PROD_W-17:0] sum;
    sum = (PROD_W - 16)'(a) + $signed(p[PROD_W-1:16]);
    return sum[COORD_W-1:0];
  endfunction

  // (npts - 1) * (b - a)
  function automatic tan_t tan_mul(coord_t a, coord_t b, logic [NPTS_W-1:0] npts);
    logic signed [DIFF_W-1:0] d;
    logic signed [NPTS_W:0]   m;
    d = DIFF_W'(b) - DIFF_W'(a);
    m = $signed({1'b0, NPTS_W'(npts - 1'b1)});
    return TAN_W'(d * m);
  endfunction

endpackage

// ===== hw/rtl/bezier_point_and_tangent_unit.sv =====
// Bezier point and tangent unit: pipelined de Casteljau evaluation.
//
// Usage:
//   Configuration: cfg_wr_en/cfg_index/cfg_data write register cfg_index at the
//   clock edge; index 0 is the point count (1..6), indexes 1..6 are control
//   points with x in bits 63:32 and y in bits 31:0, Q16.16. Other indexes are
//   ignored. Write only while no item is in flight.
//   Input: an item (param_t, Q1.16, clamped to 1.0) is taken at an edge where
//   start is high and busy is low. busy is high only during reset.
//   Output: done is high for one cycle with point_x/point_y (Q16.16) and
//   tangent_x/tangent_y (dC/dt, Q20.16) of that item.
// Timing:
//   done is registered after the entry, level and final stages.
//   One item per clock; four interpolation levels, each a multiply stage and
//   an add stage, then a final multiply and add stage.
//   Results come out in order and cannot be held off; there is no backpressure.
// Reset:
//   rst clears all valid bits, sets the point count to 2 and all control
//   points to zero.
`include "bezier_point_and_tangent_unit_defines.svh"

module bezier_point_and_tangent_unit
  import bpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 start,
  output logic                 busy,
  input  logic [T_W-1:0]       param_t,
  output logic                 done,
  output logic signed [31:0]   point_x,
  output logic signed [31:0]   point_y,
  output logic signed [35:0]   tangent_x,
  output logic signed [35:0]   tangent_y
);

  logic [NPTS_W-1:0]        num_points;
  coord_t [MAX_POINTS-1:0]  cp_x;
  coord_t [MAX_POINTS-1:0]  cp_y;

  lvl_t lvl      [NUM_LEVELS+1];
  lvl_t lvl_next [NUM_LEVELS+1];
  mul_t mul      [NUM_LEVELS];
  mul_t mul_next [NUM_LEVELS];
  fin_t fin;
  fin_t fin_next;

  logic accept;

  assign busy   = rst;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= NPTS_W'(2);
      cp_x       <= '0;
      cp_y       <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_NUM_POINTS) begin
        num_points <= cfg_data[NPTS_W-1:0];
      end else if (cfg_index >= REG_CP_FIRST && cfg_index <= REG_CP_LAST) begin
        cp_x[cfg_index - REG_CP_FIRST] <= cfg_data[CFG_W-1:COORD_W];
        cp_y[cfg_index - REG_CP_FIRST] <= cfg_data[COORD_W-1:0];
      end
    end
  end

  always_comb begin
    // entry stage
    lvl_next[0]       = '0;
    lvl_next[0].valid = accept;
    if (num_points == '0) begin
      lvl_next[0].npts = NPTS_W'(1);
    end else if (num_points > NPTS_W'(MAX_POINTS)) begin
      lvl_next[0].npts = NPTS_W'(MAX_POINTS);
    end else begin
      lvl_next[0].npts = num_points;
    end
    lvl_next[0].t   = (param_t > T_ONE) ? T_ONE : param_t;
    lvl_next[0].px  = cp_x;
    lvl_next[0].py  = cp_y;
    lvl_next[0].bx0 = cp_x[0];
    lvl_next[0].bx1 = cp_x[1];
    lvl_next[0].by0 = cp_y[0];
    lvl_next[0].by1 = cp_y[1];

    for (int k = 1; k <= NUM_LEVELS; k++) begin
      // multiply half of level k
      mul_next[k-1]       = '0;
      mul_next[k-1].valid = lvl[k-1].valid;
      mul_next[k-1].npts  = lvl[k-1].npts;
      mul_next[k-1].t     = lvl[k-1].t;
      mul_next[k-1].ax    = lvl[k-1].px;
      mul_next[k-1].ay    = lvl[k-1].py;
      mul_next[k-1].bx0   = lvl[k-1].bx0;
      mul_next[k-1].bx1   = lvl[k-1].bx1;
      mul_next[k-1].by0   = lvl[k-1].by0;
      mul_next[k-1].by1   = lvl[k-1].by1;
      for (int i = 0; i < MAX_POINTS - k; i++) begin
        mul_next[k-1].dx[i] = lerp_mul(lvl[k-1].px[i], lvl[k-1].px[i+1], lvl[k-1].t);
        mul_next[k-1].dy[i] = lerp_mul(lvl[k-1].py[i], lvl[k-1].py[i+1], lvl[k-1].t);
      end

      // add half of level k
      lvl_next[k]       = '0;
      lvl_next[k].valid = mul[k-1].valid;
      lvl_next[k].npts  = mul[k-1].npts;
      lvl_next[k].t     = mul[k-1].t;
      lvl_next[k].px    = mul[k-1].ax;
      lvl_next[k].py    = mul[k-1].ay;
      for (int i = 0; i < MAX_POINTS - k; i++) begin
        lvl_next[k].px[i] = lerp_add(mul[k-1].ax[i], mul[k-1].dx[i]);
        lvl_next[k].py[i] = lerp_add(mul[k-1].ay[i], mul[k-1].dy[i]);
      end
      // level npts-2 holds the last pair
      if (mul[k-1].npts == NPTS_W'(k + 2)) begin
        lvl_next[k].bx0 = lvl_next[k].px[0];
        lvl_next[k].bx1 = lvl_next[k].px[1];
        lvl_next[k].by0 = lvl_next[k].py[0];
        lvl_next[k].by1 = lvl_next[k].py[1];
      end else begin
        lvl_next[k].bx0 = mul[k-1].bx0;
        lvl_next[k].bx1 = mul[k-1].bx1;
        lvl_next[k].by0 = mul[k-1].by0;
        lvl_next[k].by1 = mul[k-1].by1;
      end
    end

    // final interpolation and tangent
    fin_next.valid  = lvl[NUM_LEVELS].valid;
    fin_next.single = (lvl[NUM_LEVELS].npts == NPTS_W'(1));
    fin_next.bx0    = lvl[NUM_LEVELS].bx0;
    fin_next.by0    = lvl[NUM_LEVELS].by0;
    fin_next.dx     = lerp_mul(lvl[NUM_LEVELS].bx0, lvl[NUM_LEVELS].bx1,
                               lvl[NUM_LEVELS].t);
    fin_next.dy     = lerp_mul(lvl[NUM_LEVELS].by0, lvl[NUM_LEVELS].by1,
                               lvl[NUM_LEVELS].t);
    fin_next.tx     = tan_mul(lvl[NUM_LEVELS].bx0, lvl[NUM_LEVELS].bx1,
                              lvl[NUM_LEVELS].npts);
    fin_next.ty     = tan_mul(lvl[NUM_LEVELS].by0, lvl[NUM_LEVELS].by1,
                              lvl[NUM_LEVELS].npts);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NUM_LEVELS; k++) begin
        lvl[k].valid <= 1'b0;
      end
      for (int k = 0; k < NUM_LEVELS; k++) begin
        mul[k].valid <= 1'b0;
      end
      fin.valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      lvl  <= lvl_next;
      mul  <= mul_next;
      fin  <= fin_next;
      done <= fin.valid;
      if (fin.single) begin
        point_x <= fin.bx0;
        point_y <= fin.by0;
      end else begin
        point_x <= lerp_add(fin.bx0, fin.dx);
        point_y <= lerp_add(fin.by0, fin.dy);
      end
      tangent_x <= fin.tx;
      tangent_y <= fin.ty;
    end
  end

  `BPT_ASSERT(a_latency, clk, rst, accept |-> ##LATENCY done)
  `BPT_ASSERT(a_no_spurious, clk, rst, done |-> $past(accept, LATENCY))
  `BPT_ASSERT(a_npts_range, clk, rst,
              lvl[0].valid |-> (lvl[0].npts >= NPTS_W'(1) && lvl[0].npts <= NPTS_W'(MAX_POINTS)))
  `BPT_ASSERT_NEXT(a_single_flat, clk, rst, fin.valid && fin.single,
                   tangent_x == '0 && tangent_y == '0)

endmodule
